/* rtl/core/ght_pkg.sv */
// Shared types and constants of the generational handle table.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package ght_pkg;

  // Default configuration of the pool.
  localparam int DEF_SLOTS    = 256;
  localparam int DEF_GEN_BITS = 16;

  // Saturation limit of the reference count.
  localparam logic [31:0] REFCOUNT_MAX = 32'hFFFF_FFFF;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  // Operation codes of a request.
  localparam cmd_t CMD_ALLOC   = 2'd0;
  localparam cmd_t CMD_CHECK   = 2'd1;
  localparam cmd_t CMD_RETAIN  = 2'd2;
  localparam cmd_t CMD_RELEASE = 2'd3;

  // Result status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_FREED   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;     // clearing pass writes one entry
    logic accept;  // a request is taken this cycle
    logic pop;     // free-stack data is ready, slot read uses the popped index
    logic commit;  // result is written back and loaded into the output register
  } ght_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic alloc_pop;  // incoming request is an allocate with a free slot
    logic out_free;   // output register can take a result this cycle
    logic clr_last;   // clearing pass is at its last entry
  } ght_stat_t;

endpackage

/* rtl/core/ght_req_if.sv */
// Request channel of the generational handle table.
// Depends on ght_pkg for the command type.
`timescale 1ns / 1ps

interface ght_req_if import ght_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_t        cmd;
  logic [15:0] handle_index;
  logic [15:0] handle_generation;
  logic [7:0]  obj_type;

  modport source (output valid, cmd, handle_index, handle_generation, obj_type,
                  input ready);
  modport sink   (input valid, cmd, handle_index, handle_generation, obj_type,
                  output ready);
endinterface

/* rtl/core/ght_rsp_if.sv */
// Result channel of the generational handle table.
// Depends on ght_pkg for the status type.
`timescale 1ns / 1ps

interface ght_rsp_if import ght_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] out_index;
  logic [15:0] out_generation;
  logic [7:0]  out_type;
  logic [31:0] out_refcount;

  modport source (output valid, status, out_index, out_generation, out_type,
                  out_refcount, input ready);
  modport sink   (input valid, status, out_index, out_generation, out_type,
                  out_refcount, output ready);
endinterface

/* rtl/core/ght_ctrl.sv */
// Sequencer of the generational handle table: clearing pass, accept, pop, commit.
// Depends on ght_pkg for the command and status structs.
`timescale 1ns / 1ps

module ght_ctrl import ght_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ght_stat_t stat,
  output ght_ctl_t  ctl
);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_EXE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // A request is taken only while no other one is in flight.
  assign in_ready = (state_r == S_IDLE);

  // Command decode and next state.
  always_comb begin
    ctl        = '0;
    state_nxt  = state_r;
    ctl.clr    = (state_r == S_CLR);
    ctl.accept = in_ready && in_valid;
    ctl.pop    = (state_r == S_POP);
    ctl.commit = (state_r == S_EXE) && stat.out_free;
    case (state_r)
      S_CLR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (ctl.accept) state_nxt = stat.alloc_pop ? S_POP : S_EXE;
      end
      S_POP: begin
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/ght_datapath.sv */
// Datapath of the generational handle table: slot memories, free stack, output register.
// Depends on ght_pkg; driven by ght_ctrl through the command struct.
`timescale 1ns / 1ps

module ght_datapath import ght_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int GEN_BITS = DEF_GEN_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ght_ctl_t    ctl,
  output ght_stat_t   stat,
  input  cmd_t        in_cmd,
  input  logic [15:0] in_handle_index,
  input  logic [15:0] in_handle_generation,
  input  logic [7:0]  in_obj_type,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     out_status,
  output logic [15:0] out_index,
  output logic [15:0] out_generation,
  output logic [7:0]  out_type,
  output logic [31:0] out_refcount
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int DEPTH_W = $clog2(SLOTS + 1);
  localparam int CMP_W   = (GEN_BITS > 16) ? GEN_BITS : 16;

  // Memories.
  logic [IDX_W-1:0]    stack_mem [SLOTS];
  logic [GEN_BITS-1:0] gen_mem   [SLOTS];
  logic [31:0]         rc_mem    [SLOTS];
  logic [7:0]          type_mem  [SLOTS];

  logic [IDX_W-1:0]    stack_rdata_r;
  logic [GEN_BITS-1:0] gen_rdata_r;
  logic [31:0]         rc_rdata_r;
  logic [7:0]          type_rdata_r;

  // Control state.
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [IDX_W-1:0]   clr_cnt_r;
  logic               out_valid_r;

  // Latched request.
  cmd_t             cmd_r;
  logic [15:0]      idx_r;
  logic [15:0]      hgen_r;
  logic [7:0]       type_r;
  logic             inr_r;
  logic             empty_r;
  logic [IDX_W-1:0] addr_r;

  // Output payload.
  status_t     status_r;
  logic [15:0] oidx_r;
  logic [15:0] ogen_r;
  logic [7:0]  otype_r;
  logic [31:0] orc_r;

  logic               empty;
  logic               in_range;
  logic [IDX_W-1:0]   in_addr;
  logic [DEPTH_W-1:0] depth_m1;
  logic [IDX_W-1:0]   stk_raddr;
  logic [IDX_W-1:0]   slot_raddr;
  logic               slot_rd;

  logic                live;
  logic [GEN_BITS-1:0] gen_bump;
  logic [31:0]         rc_sat;
  logic [31:0]         rc_dec;
  logic [31:0]         rc_new;
  logic                gen_upd;
  logic                rc_upd;
  logic                type_upd;
  logic                push;
  logic                push_ok;
  logic                pop_commit;
  status_t             res_status;
  logic [15:0]         res_index;
  logic [15:0]         res_gen;
  logic [7:0]          res_type;
  logic [31:0]         res_rc;

  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [IDX_W-1:0]    stk_wdata;
  logic [IDX_W-1:0]    slot_waddr;
  logic                gen_we;
  logic [GEN_BITS-1:0] gen_wdata;
  logic                rc_we;
  logic [31:0]         rc_wdata;

  // Request-side decode: range check, read addresses and status to the controller.
  always_comb begin
    empty          = (depth_r == '0);
    in_range       = (17'(in_handle_index) < 17'(SLOTS));
    in_addr        = in_range ? in_handle_index[IDX_W-1:0] : '0;
    depth_m1       = depth_r - DEPTH_W'(1);
    stk_raddr      = empty ? '0 : depth_m1[IDX_W-1:0];
    slot_raddr     = ctl.pop ? stack_rdata_r : in_addr;
    slot_rd        = ctl.accept || ctl.pop;
    stat.alloc_pop = (in_cmd == CMD_ALLOC) && !empty;
    stat.out_free  = !out_valid_r || out_ready;
    stat.clr_last  = (clr_cnt_r == IDX_W'(SLOTS - 1));
  end

  // Operation on the slot that was read: validity, new counts and the result.
  always_comb begin
    live       = inr_r && (CMP_W'(gen_rdata_r) == CMP_W'(hgen_r)) && (rc_rdata_r != '0);
    gen_bump   = gen_rdata_r + GEN_BITS'(1);
    rc_sat     = (rc_rdata_r == REFCOUNT_MAX) ? rc_rdata_r : rc_rdata_r + 32'd1;
    rc_dec     = rc_rdata_r - 32'd1;
    rc_new     = rc_rdata_r;
    gen_upd    = 1'b0;
    rc_upd     = 1'b0;
    type_upd   = 1'b0;
    push       = 1'b0;
    pop_commit = 1'b0;
    res_status = ST_OK;
    res_index  = idx_r;
    res_gen    = '0;
    res_type   = '0;
    res_rc     = '0;
    case (cmd_r)
      CMD_ALLOC: begin
        if (empty_r) begin
          res_status = ST_FULL;
          res_index  = '0;
        end else begin
          pop_commit = 1'b1;
          gen_upd    = 1'b1;
          rc_upd     = 1'b1;
          type_upd   = 1'b1;
          rc_new     = 32'd1;
          res_index  = 16'(addr_r);
          res_gen    = 16'(gen_bump);
          res_type   = type_r;
          res_rc     = 32'd1;
        end
      end
      default: begin
        if (!live) begin
          res_status = ST_INVALID;
        end else begin
          res_gen  = 16'(gen_rdata_r);
          res_type = type_rdata_r;
          res_rc   = rc_rdata_r;
          case (cmd_r)
            CMD_RETAIN: begin
              rc_upd = 1'b1;
              rc_new = rc_sat;
              res_rc = rc_sat;
            end
            CMD_RELEASE: begin
              rc_upd = 1'b1;
              rc_new = rc_dec;
              res_rc = rc_dec;
              if (rc_dec == '0) begin
                gen_upd    = 1'b1;
                push       = 1'b1;
                res_status = ST_FREED;
                res_gen    = 16'(gen_bump);
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase
    push_ok = push && (depth_r < DEPTH_W'(SLOTS));
  end

  // Write ports: the clearing pass or the commit of an operation.
  always_comb begin
    slot_waddr = ctl.clr ? clr_cnt_r : addr_r;
    gen_we     = ctl.clr || (ctl.commit && gen_upd);
    gen_wdata  = ctl.clr ? '0 : gen_bump;
    rc_we      = ctl.clr || (ctl.commit && rc_upd);
    rc_wdata   = ctl.clr ? '0 : rc_new;
    stk_we     = ctl.clr || (ctl.commit && push_ok);
    stk_waddr  = ctl.clr ? clr_cnt_r : depth_r[IDX_W-1:0];
    stk_wdata  = ctl.clr ? (IDX_W'(SLOTS - 1) - clr_cnt_r) : addr_r;
  end

  // Free-index stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (ctl.accept) stack_rdata_r <= stack_mem[stk_raddr];
  end

  // Slot generation memory.
  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[slot_waddr] <= gen_wdata;
    if (slot_rd) gen_rdata_r <= gen_mem[slot_raddr];
  end

  // Slot reference count memory.
  always_ff @(posedge clk) begin
    if (rc_we) rc_mem[slot_waddr] <= rc_wdata;
    if (slot_rd) rc_rdata_r <= rc_mem[slot_raddr];
  end

  // Slot type memory; only live slots are ever read back, so it is not cleared.
  always_ff @(posedge clk) begin
    if (ctl.commit && type_upd) type_mem[addr_r] <= type_r;
    if (slot_rd) type_rdata_r <= type_mem[slot_raddr];
  end

  // Stack depth follows pops and pushes.
  always_comb begin
    depth_nxt = depth_r;
    if (ctl.commit && pop_commit) begin
      depth_nxt = depth_m1;
    end else if (ctl.commit && push_ok) begin
      depth_nxt = depth_r + DEPTH_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_W'(SLOTS);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      if (ctl.clr) clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture; on a pop the popped index becomes the slot address.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= in_cmd;
      idx_r   <= in_handle_index;
      hgen_r  <= in_handle_generation;
      type_r  <= in_obj_type;
      inr_r   <= in_range;
      empty_r <= empty;
      addr_r  <= in_addr;
    end else if (ctl.pop) begin
      addr_r <= stack_rdata_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status_r <= res_status;
      oidx_r   <= res_index;
      ogen_r   <= res_gen;
      otype_r  <= res_type;
      orc_r    <= res_rc;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_index      = oidx_r;
  assign out_generation = ogen_r;
  assign out_type       = otype_r;
  assign out_refcount   = orc_r;

`ifndef SYNTH
  // The free stack never holds more than the whole pool.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(SLOTS))
    else $error("free stack depth above pool size");

  // A committed operation always presents its result in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid_r)
    else $error("committed result not presented");

  // A successful allocate takes exactly one index off the stack.
  a_alloc_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && cmd_r == CMD_ALLOC && !empty_r) |=>
      depth_r == $past(depth_r) - DEPTH_W'(1))
    else $error("allocate did not pop one free index");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ctl.commit)
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/core/generational_handle_table.sv */
// Top level of the generational handle table: a pool of slots with generations and refcounts.
// Depends on ght_pkg, ght_req_if, ght_rsp_if, ght_ctrl and ght_datapath.
//
//   Channel  Direction  Handshake          Payload
//   in_req   sink       valid / ready      cmd, handle_index, handle_generation, obj_type
//   out_rsp  source     valid / ready      status, out_index, out_generation, out_type,
//                                          out_refcount
//
// Check, retain and release read the slot memories when the request is taken, then
// update them and load the output register in the commit step. An allocate that finds a
// free slot adds a pop step, since the free-stack read must finish before the slot read
// that uses the popped index; an allocate that finds the pool full goes straight to commit.
// After reset a clearing pass over all SLOTS entries initializes the free stack, generations
// and refcounts; no request is taken during it.
// A result waiting in the output register holds the block in its commit step.
`timescale 1ns / 1ps

module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int GEN_BITS = DEF_GEN_BITS
) (
  input logic   clk,
  input logic   rst_n,
  ght_req_if.sink   in_req,
  ght_rsp_if.source out_rsp
);

  ght_ctl_t  ctl;
  ght_stat_t stat;

  // Sequencer.
  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Memories and result logic.
  ght_datapath #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .stat                 (stat),
    .in_cmd               (in_req.cmd),
    .in_handle_index      (in_req.handle_index),
    .in_handle_generation (in_req.handle_generation),
    .in_obj_type          (in_req.obj_type),
    .out_valid            (out_rsp.valid),
    .out_ready            (out_rsp.ready),
    .out_status           (out_rsp.status),
    .out_index            (out_rsp.out_index),
    .out_generation       (out_rsp.out_generation),
    .out_type             (out_rsp.out_type),
    .out_refcount         (out_rsp.out_refcount)
  );

endmodule
